[src/tkdlp_pkg.sv]
// ----------------------------------------------------------------------------
// tkdlp_pkg
// Shared types and constants for the two-key debouncer with long press.
// ----------------------------------------------------------------------------
`default_nettype none

package tkdlp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_DOWN = 4'b0010,
        PH_HOLD = 4'b0100,
        PH_UP   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_ADD     = 2'd1,
        EV_CONFIRM = 2'd2,
        EV_RESET   = 2'd3
    } event_t;

    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE      = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS    = 2'd2;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_TAKE   = 1'b1;

    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd10;
    localparam logic [3:0]  DEBOUNCE_RST      = 4'd3;
    localparam logic [15:0] LONG_PRESS_RST    = 16'd2000;

    typedef struct packed {
        logic press_done;
        logic hold;
        logic release_lvl;
    } key_stat_t;

endpackage

`default_nettype wire

[src/two_key_debounce_long_press.sv]
// ----------------------------------------------------------------------------
// two_key_debounce_long_press
// Two active-low button qualifier with add, confirm and long-press events.
// ----------------------------------------------------------------------------
// Input channel (s_*): one beat is either a pin sample (kind 0) with both
// pin levels and a ms timestamp, or a take request (kind 1).
// Result channel (m_*): one beat per take request, carrying the pending
// event (none, add, confirm, reset); samples produce no beat.
// Config channel (cfg_*): index 0 sample period, 1 debounce count,
// 2 long-press time; always ready, write only while idle.
// Result path: a take beat waits in the input register until the output
// register is free or being taken, then moves there and m_valid rises.
// Throughput: one beat per cycle while no take beat waits on a blocked
// result; input register feeds one pass of compare and counter logic into the state and the output register.
// Reset: aresetn low for one cycle clears both key machines, the event
// slot and the timers, and restores the config defaults.
// Stall: while m_ready is low a pending result is held and further sample
// beats still flow; a second take waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module two_key_debounce_long_press (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_add_level,
    input  wire logic        s_confirm_level,
    input  wire logic [31:0] s_time_ms,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [1:0]  m_event_res,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        in_valid_reg;
    logic        in_kind_reg;
    logic        in_add_reg;
    logic        in_conf_reg;
    logic [31:0] in_time_reg;

    logic [15:0] period_reg;
    logic [3:0]  debounce_reg;
    logic [15:0] long_reg;

    logic [31:0] last_time_reg, last_time_next;
    logic [31:0] start_time_reg, start_time_next;
    logic        long_fired_reg, long_fired_next;
    tkdlp_pkg::event_t pending_reg, pending_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_event_reg, m_event_next;

    logic        advance;
    logic        take_fire;
    logic        sample_en;
    logic [31:0] since_last;
    logic [31:0] held_ms;
    logic        fire_reset;
    logic        fire_confirm;
    tkdlp_pkg::event_t raised;

    tkdlp_pkg::key_stat_t add_stat;
    tkdlp_pkg::key_stat_t conf_stat;

    assign advance   = in_valid_reg &&
                       ((in_kind_reg == tkdlp_pkg::KIND_SAMPLE) || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign take_fire = advance && (in_kind_reg == tkdlp_pkg::KIND_TAKE);
    assign cfg_ready = 1'b1;

    assign since_last = in_time_reg - last_time_reg;
    assign held_ms    = in_time_reg - start_time_reg;
    assign sample_en  = advance && (in_kind_reg == tkdlp_pkg::KIND_SAMPLE) &&
                        (since_last >= {16'd0, period_reg});

    tkdlp_key u_add_key (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .sample_en        (sample_en),
        .level            (in_add_reg),
        .debounce_samples (debounce_reg),
        .stat             (add_stat)
    );

    tkdlp_key u_conf_key (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .sample_en        (sample_en),
        .level            (in_conf_reg),
        .debounce_samples (debounce_reg),
        .stat             (conf_stat)
    );

    assign fire_reset   = conf_stat.hold && !long_fired_reg &&
                          (held_ms >= {16'd0, long_reg});
    assign fire_confirm = conf_stat.release_lvl && !long_fired_reg && !fire_reset;

    always_comb begin
        if (add_stat.press_done) begin
            raised = tkdlp_pkg::EV_ADD;
        end else if (fire_reset) begin
            raised = tkdlp_pkg::EV_RESET;
        end else if (fire_confirm) begin
            raised = tkdlp_pkg::EV_CONFIRM;
        end else begin
            raised = tkdlp_pkg::EV_NONE;
        end
    end

    always_comb begin
        last_time_next  = last_time_reg;
        start_time_next = start_time_reg;
        long_fired_next = long_fired_reg;
        pending_next    = pending_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_event_next    = m_event_reg;
        if (take_fire) begin
            m_valid_next = 1'b1;
            m_event_next = pending_reg;
            pending_next = tkdlp_pkg::EV_NONE;
        end
        if (sample_en) begin
            last_time_next = in_time_reg;
            if (conf_stat.press_done) begin
                start_time_next = in_time_reg;
                long_fired_next = 1'b0;
            end else if (fire_reset) begin
                long_fired_next = 1'b1;
            end
            if (pending_reg == tkdlp_pkg::EV_NONE) begin
                pending_next = raised;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_add_reg  <= s_add_level;
            in_conf_reg <= s_confirm_level;
            in_time_reg <= s_time_ms;
        end
        m_event_reg <= m_event_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            period_reg     <= tkdlp_pkg::SAMPLE_PERIOD_RST;
            debounce_reg   <= tkdlp_pkg::DEBOUNCE_RST;
            long_reg       <= tkdlp_pkg::LONG_PRESS_RST;
            last_time_reg  <= 32'd0;
            start_time_reg <= 32'd0;
            long_fired_reg <= 1'b0;
            pending_reg    <= tkdlp_pkg::EV_NONE;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            m_valid_reg    <= m_valid_next;
            last_time_reg  <= last_time_next;
            start_time_reg <= start_time_next;
            long_fired_reg <= long_fired_next;
            pending_reg    <= pending_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tkdlp_pkg::CFG_SAMPLE_PERIOD: period_reg   <= cfg_data;
                    tkdlp_pkg::CFG_DEBOUNCE:      debounce_reg <= cfg_data[3:0];
                    tkdlp_pkg::CFG_LONG_PRESS:    long_reg     <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_event_res = m_event_reg;

`ifndef SYNTHESIS
    a_slot_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg != tkdlp_pkg::EV_NONE && !take_fire) |=> $stable(pending_reg))
        else $error("pending event overwritten");

    a_take_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take_fire |=> (m_valid && pending_reg == tkdlp_pkg::EV_NONE))
        else $error("take did not produce a beat or clear the slot");

    a_stall_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_reset_once: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_reset |=> long_fired_reg)
        else $error("long press not recorded");
`endif

endmodule

`default_nettype wire

[src/tkdlp_key.sv]
// ----------------------------------------------------------------------------
// tkdlp_key
// Per-key idle / debounce-down / hold / debounce-up machine with run counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tkdlp_key (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              sample_en,
    input  wire logic              level,
    input  wire logic [3:0]        debounce_samples,
    output tkdlp_pkg::key_stat_t   stat
);

    tkdlp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]        run_reg, run_next;
    logic [3:0]        bump;
    logic              confirmed;

    assign bump      = (run_reg != 4'hF) ? run_reg + 4'd1 : run_reg;
    assign confirmed = bump >= debounce_samples;

    always_comb begin
        phase_next       = phase_reg;
        run_next         = run_reg;
        stat.press_done  = 1'b0;
        stat.hold        = sample_en && (phase_reg == tkdlp_pkg::PH_HOLD);
        stat.release_lvl = sample_en && (phase_reg == tkdlp_pkg::PH_HOLD) && level;
        if (sample_en) begin
            case (phase_reg)
                tkdlp_pkg::PH_IDLE: begin
                    if (!level) begin
                        run_next   = 4'd1;
                        phase_next = tkdlp_pkg::PH_DOWN;
                    end
                end
                tkdlp_pkg::PH_DOWN: begin
                    if (!level) begin
                        run_next = bump;
                        if (confirmed) begin
                            phase_next      = tkdlp_pkg::PH_HOLD;
                            stat.press_done = 1'b1;
                        end
                    end else begin
                        phase_next = tkdlp_pkg::PH_IDLE;
                    end
                end
                tkdlp_pkg::PH_HOLD: begin
                    if (level) begin
                        run_next   = 4'd1;
                        phase_next = tkdlp_pkg::PH_UP;
                    end
                end
                tkdlp_pkg::PH_UP: begin
                    if (level) begin
                        run_next = bump;
                        if (confirmed) begin
                            phase_next = tkdlp_pkg::PH_IDLE;
                        end
                    end else begin
                        phase_next = tkdlp_pkg::PH_HOLD;
                    end
                end
                default: begin
                    phase_next = tkdlp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tkdlp_pkg::PH_IDLE;
            run_reg   <= 4'd0;
        end else begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
        end
    end

endmodule

`default_nettype wire

[tb/key_event_checker.sv]
// ----------------------------------------------------------------------------
// key_event_checker
// Watches the sample, result and register channels of the two-key
// debouncer. It runs its own copy of both key machines and the event slot on
// every accepted sample beat, queues the event that each take beat must
// return, and compares every result beat against the oldest queued event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_event_checker
    import tkdlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_add_level,
    input  wire logic        s_confirm_level,
    input  wire logic [31:0] s_time_ms,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_event_res,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int unsigned      events_owed,
    output int unsigned      miss_count
);

    logic [15:0] period_ms;
    logic [3:0]  settle_cnt;
    logic [15:0] long_ms;

    phase_t      add_ph;
    phase_t      cf_ph;
    logic [3:0]  add_run;
    logic [3:0]  cf_run;
    logic [31:0] hold_t0;
    logic [31:0] last_t;
    logic        long_done;
    event_t      slot;

    event_t      events_due[$];
    int unsigned misses;

    function automatic logic [3:0] run_inc(input logic [3:0] run);
        return (run == 4'd15) ? run : run + 4'd1;
    endfunction

    task automatic post_event(input event_t ev);
        if (slot == EV_NONE) begin
            slot = ev;
        end
    endtask

    task automatic clear_keys();
        period_ms  = SAMPLE_PERIOD_RST;
        settle_cnt = DEBOUNCE_RST;
        long_ms    = LONG_PRESS_RST;
        add_ph     = PH_IDLE;
        cf_ph      = PH_IDLE;
        add_run    = 4'd0;
        cf_run     = 4'd0;
        hold_t0    = 32'd0;
        last_t     = 32'd0;
        long_done  = 1'b0;
        slot       = EV_NONE;
    endtask

    task automatic step_keys(input logic add_lvl, input logic cf_lvl, input logic [31:0] now);
        logic [31:0] gap;
        logic [31:0] held;
        gap = now - last_t;
        if (gap < {16'd0, period_ms}) begin
            return;
        end
        last_t = now;

        case (add_ph)
            PH_IDLE: begin
                if (!add_lvl) begin
                    add_run = 4'd1;
                    add_ph  = PH_DOWN;
                end
            end
            PH_DOWN: begin
                if (!add_lvl) begin
                    add_run = run_inc(add_run);
                    if (add_run >= settle_cnt) begin
                        add_ph = PH_HOLD;
                        post_event(EV_ADD);
                    end
                end else begin
                    add_ph = PH_IDLE;
                end
            end
            PH_HOLD: begin
                if (add_lvl) begin
                    add_run = 4'd1;
                    add_ph  = PH_UP;
                end
            end
            default: begin
                if (add_lvl) begin
                    add_run = run_inc(add_run);
                    if (add_run >= settle_cnt) begin
                        add_ph = PH_IDLE;
                    end
                end else begin
                    add_ph = PH_HOLD;
                end
            end
        endcase

        case (cf_ph)
            PH_IDLE: begin
                if (!cf_lvl) begin
                    cf_run = 4'd1;
                    cf_ph  = PH_DOWN;
                end
            end
            PH_DOWN: begin
                if (!cf_lvl) begin
                    cf_run = run_inc(cf_run);
                    if (cf_run >= settle_cnt) begin
                        cf_ph     = PH_HOLD;
                        hold_t0   = now;
                        long_done = 1'b0;
                    end
                end else begin
                    cf_ph = PH_IDLE;
                end
            end
            PH_HOLD: begin
                held = now - hold_t0;
                if (!long_done && held >= {16'd0, long_ms}) begin
                    long_done = 1'b1;
                    post_event(EV_RESET);
                end
                if (cf_lvl) begin
                    if (!long_done) begin
                        post_event(EV_CONFIRM);
                    end
                    cf_run = 4'd1;
                    cf_ph  = PH_UP;
                end
            end
            default: begin
                if (cf_lvl) begin
                    cf_run = run_inc(cf_run);
                    if (cf_run >= settle_cnt) begin
                        cf_ph = PH_IDLE;
                    end
                end else begin
                    cf_ph = PH_HOLD;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        event_t want;
        if (!aresetn) begin
            clear_keys();
            events_due.delete();
            misses = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SAMPLE_PERIOD: period_ms  = cfg_data;
                    CFG_DEBOUNCE:      settle_cnt = cfg_data[3:0];
                    CFG_LONG_PRESS:    long_ms    = cfg_data;
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (events_due.size() == 0) begin
                    misses++;
                    if (misses <= 10) begin
                        $display("%0t: result beat with nothing owed, event %0d",
                                 $realtime, m_event_res);
                    end
                end else begin
                    want = events_due.pop_front();
                    if (m_event_res !== want) begin
                        misses++;
                        if (misses <= 10) begin
                            $display("%0t: event_res expected %0d got %0d",
                                     $realtime, want, m_event_res);
                        end
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_kind == KIND_TAKE) begin
                    events_due.push_back(slot);
                    slot = EV_NONE;
                end else begin
                    step_keys(s_add_level, s_confirm_level, s_time_ms);
                end
            end
        end
        events_owed <= events_due.size();
        miss_count  <= misses;
    end

endmodule

[tb/two_key_debounce_long_press_tb.sv]
// ----------------------------------------------------------------------------
// two_key_debounce_long_press_tb
// Drives the two-key debouncer with a short directed sequence and then
// bursts of random key traffic under several register settings, with random
// gaps on the sample side and random stalls on the result side. Checking is
// done by key_event_checker; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_key_debounce_long_press_tb;
    import tkdlp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          PHASE_ITEMS = 222;
    localparam int          LONG_HOLD   = 300;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_kind          = KIND_SAMPLE;
    logic        s_add_level     = 1'b1;
    logic        s_confirm_level = 1'b1;
    logic [31:0] s_time_ms       = 32'd0;
    logic        m_ready         = 1'b0;
    logic        cfg_valid       = 1'b0;
    logic [1:0]  cfg_index       = CFG_SAMPLE_PERIOD;
    logic [15:0] cfg_data        = 16'd0;

    wire logic       s_ready;
    wire logic       m_valid;
    wire logic [1:0] m_event_res;
    wire logic       cfg_ready;

    int unsigned events_owed;
    int unsigned miss_count;
    int unsigned cycles   = 0;
    logic        hold_req = 1'b0;

    logic [31:0] now_ms     = 32'd0;
    int unsigned cur_period = 32'(SAMPLE_PERIOD_RST);
    int unsigned cur_settle = 32'(DEBOUNCE_RST);
    int unsigned cur_long   = 32'(LONG_PRESS_RST);
    logic        add_down   = 1'b0;
    logic        cf_down    = 1'b0;

    two_key_debounce_long_press uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_add_level     (s_add_level),
        .s_confirm_level (s_confirm_level),
        .s_time_ms       (s_time_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    key_event_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_add_level     (s_add_level),
        .s_confirm_level (s_confirm_level),
        .s_time_ms       (s_time_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .events_owed     (events_owed),
        .miss_count      (miss_count)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("two_key_debounce_long_press: mismatch");
            $finish;
        end
    end

    // result side: random ready pattern, plus a long hold-off on request
    initial begin : rx_pattern
        logic ack;
        int   mode;
        int   len;
        ack = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req != ack) begin
                ack = hold_req;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 4);
                len  = $urandom_range(1, 40);
                repeat (len) begin
                    case (mode)
                        0, 1: m_ready <= 1'b1;
                        2: m_ready <= 1'($urandom_range(0, 1));
                        3: m_ready <= ($urandom_range(0, 7) != 0);
                        default: m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    task automatic send_beat(input logic kind, input logic add_lvl, input logic cf_lvl,
                             input logic [31:0] t);
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_add_level     <= add_lvl;
        s_confirm_level <= cf_lvl;
        s_time_ms       <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic press_sample(input logic add_lvl, input logic cf_lvl,
                                input int unsigned step);
        now_ms = now_ms + step;
        send_beat(KIND_SAMPLE, add_lvl, cf_lvl, now_ms);
    endtask

    task automatic take_event();
        send_beat(KIND_TAKE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic pause(input int n);
        if (n == 0) begin
            return;
        end
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // sender holds off until every owed result beat is back, then lets the
    // pipeline empty of sample beats
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (events_owed != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setting(input int unsigned per, input int unsigned deb,
                                 input int unsigned lng);
        write_reg(CFG_SAMPLE_PERIOD, per[15:0]);
        write_reg(CFG_DEBOUNCE, deb[15:0]);
        write_reg(CFG_LONG_PRESS, lng[15:0]);
        cfg_valid <= 1'b0;
        cur_period = per;
        cur_settle = deb;
        cur_long   = lng;
    endtask

    task automatic run_traffic(input int n_items);
        int          done;
        int          burst;
        int          pick;
        int unsigned step;
        logic        a_lvl;
        logic        c_lvl;
        done = 0;
        while (done < n_items) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 20);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    take_event();
                    done++;
                end else if (pick < 24) begin
                    now_ms = $urandom;
                    send_beat(KIND_SAMPLE, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), now_ms);
                    done++;
                end else if (pick < 28 && cur_period > 0) begin
                    // step below the period; may be dropped as too early
                    press_sample(!add_down, !cf_down, $urandom_range(0, cur_period - 1));
                end else begin
                    if ($urandom_range(0, 2 * cur_settle + 5) == 0) add_down = !add_down;
                    if ($urandom_range(0, 2 * cur_settle + 5) == 0) cf_down = !cf_down;
                    a_lvl = !add_down;
                    c_lvl = !cf_down;
                    if ($urandom_range(0, 11) == 0) a_lvl = !a_lvl;
                    if ($urandom_range(0, 11) == 0) c_lvl = !c_lvl;
                    if ($urandom_range(0, 14) == 0)
                        step = cur_period + $urandom_range(0, 2 * cur_long + 1);
                    else
                        step = cur_period + $urandom_range(0, 3);
                    press_sample(a_lvl, c_lvl, step);
                    done++;
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                pause($urandom_range(1, 12));
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, default settings
        take_event();
        now_ms = 32'd0;
        press_sample(1'b1, 1'b1, 5);
        now_ms = 32'hFFFF_FFF5;
        press_sample(1'b1, 1'b1, 10);
        repeat (3) press_sample(1'b0, 1'b1, 10);
        repeat (3) press_sample(1'b1, 1'b0, 10);
        press_sample(1'b1, 1'b1, 10);
        take_event();
        repeat (2) press_sample(1'b1, 1'b1, 10);
        repeat (3) press_sample(1'b1, 1'b0, 10);
        press_sample(1'b1, 1'b0, 2000);
        press_sample(1'b1, 1'b1, 10);
        press_sample(1'b1, 1'b0, 10);
        press_sample(1'b1, 1'b1, 10);
        take_event();
        take_event();

        // long result stall while beats keep coming
        hold_req <= ~hold_req;
        run_traffic(PHASE_ITEMS);
        settle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_setting(1, 1, 5);
                1: apply_setting(0, 0, 0);
                2: apply_setting(65535, 15, 65535);
                3: apply_setting(7, 2, 60);
                7: apply_setting(SAMPLE_PERIOD_RST, DEBOUNCE_RST, LONG_PRESS_RST);
                default: apply_setting($urandom_range(1, 40), $urandom_range(0, 15),
                                       $urandom_range(0, 300));
            endcase
            if (ph[0]) begin
                now_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * cur_period);
            end
            run_traffic(PHASE_ITEMS);
            settle();
        end

        if (miss_count == 0 && events_owed == 0) begin
            $display("two_key_debounce_long_press: match");
        end else begin
            $display("two_key_debounce_long_press: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
src/tkdlp_pkg.sv
src/tkdlp_key.sv
src/two_key_debounce_long_press.sv
tb/key_event_checker.sv
tb/two_key_debounce_long_press_tb.sv
